// File: src/ascii_command_frame_parser_macros.svh
// Assertion macros shared by the frame parser RTL.
`ifndef ASCII_COMMAND_FRAME_PARSER_MACROS_SVH
`define ASCII_COMMAND_FRAME_PARSER_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define ACFP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ACFP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/acfp_pkg.sv
// Types and character constants for the ASCII command frame parser.
`default_nettype none

package acfp_pkg;

	typedef logic [7:0] byte_t;
	typedef logic signed [10:0] level_t;

	localparam byte_t CH_LT    = 8'h3C;
	localparam byte_t CH_GT    = 8'h3E;
	localparam byte_t CH_DOT   = 8'h2E;
	localparam byte_t CH_M     = 8'h4D;
	localparam byte_t CH_P     = 8'h50;
	localparam byte_t CH_A     = 8'h41;
	localparam byte_t CH_D     = 8'h44;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_ZERO  = 8'h30;
	localparam byte_t CH_NINE  = 8'h39;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_CR    = 8'h0D;

	localparam level_t LEVEL_MIN = -11'sd99;
	localparam level_t LEVEL_MAX = 11'sd999;

	// Largest number of levels that are stored and reported.
	localparam int NUM_LEVELS_MAX = 3;

endpackage

`default_nettype wire

// File: src/acfp_conv.sv
// Converts one text field to a saturated level value.
`default_nettype none

module acfp_conv #(
	parameter int FIELD_CHARS = 3
) (
	input  wire logic [FIELD_CHARS-1:0][7:0] chars,
	output acfp_pkg::level_t                 value
);
	import acfp_pkg::*;

	localparam logic [1:0] SC_SKIP = 2'd0;
	localparam logic [1:0] SC_DIG  = 2'd1;
	localparam logic [1:0] SC_STOP = 2'd2;

	logic [1:0]  scan;
	logic [9:0]  acc;
	logic [13:0] prod;
	logic        neg;
	logic        is_dig;
	logic        is_blank;
	byte_t       c;

	// Scan the characters: blanks, an optional sign, then digits.
	// The accumulator saturates at 1000, which is past every clamp limit.
	always_comb begin
		scan     = SC_SKIP;
		acc      = '0;
		prod     = '0;
		neg      = 1'b0;
		is_dig   = 1'b0;
		is_blank = 1'b0;
		c        = '0;
		for (int i = 0; i < FIELD_CHARS; i++) begin
			c        = chars[i];
			is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
			is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
			prod     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, c[3:0]};
			case (scan)
				SC_SKIP: begin
					if (is_blank) begin
						scan = SC_SKIP;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg  = (c == CH_MINUS);
						scan = SC_DIG;
					end else if (is_dig) begin
						acc  = {6'b0, c[3:0]};
						scan = SC_DIG;
					end else begin
						scan = SC_STOP;
					end
				end
				SC_DIG: begin
					if (is_dig) begin
						acc = (prod >= 14'd1000) ? 10'd1000 : prod[9:0];
					end else begin
						scan = SC_STOP;
					end
				end
				default: begin
					scan = SC_STOP;
				end
			endcase
		end
	end

	// Apply the sign and clamp to the level range.
	always_comb begin
		if (neg) begin
			value = (acc > 10'd99) ? LEVEL_MIN : -level_t'({1'b0, acc});
		end else begin
			value = (acc > 10'd999) ? LEVEL_MAX : level_t'({1'b0, acc});
		end
	end

endmodule

`default_nettype wire

// File: src/ascii_command_frame_parser.sv
// An accepted byte waits in the input register and moves into the result register
// once that register is free or being emptied. Throughput: one byte per cycle
// unless out_ready stalls the result register; the input register and the result
// register are the only stages, and the parse state updates in one pass.
// Reset clears the parse phase, field counters, levels to zero, suction
// off, and empties both stages; field text needs no reset.
// Top level of the ASCII command frame parser.
`default_nettype none

module ascii_command_frame_parser #(
	parameter int FIELD_CHARS = 3,
	parameter int NUM_FIELDS  = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire acfp_pkg::byte_t  rx_byte,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  suction_on,
	output logic                  suction_changed,
	output acfp_pkg::level_t      level_a,
	output acfp_pkg::level_t      level_b,
	output acfp_pkg::level_t      level_c,
	output logic [2:0]            level_changed_mask
);
	import acfp_pkg::*;

	`include "ascii_command_frame_parser_macros.svh"

	localparam int NUM_LEVELS = (NUM_FIELDS < NUM_LEVELS_MAX) ? NUM_FIELDS : NUM_LEVELS_MAX;
	localparam int POS_W      = $clog2(FIELD_CHARS + 1);
	localparam int SLOT_W     = $clog2(NUM_FIELDS + 1);

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_CMD    = 2'd1;
	localparam logic [1:0] PH_LEVELS = 2'd2;
	localparam logic [1:0] PH_END    = 2'd3;

	typedef logic [NUM_LEVELS-1:0][FIELD_CHARS-1:0][7:0] fields_t;

	byte_t        byte_s1;
	logic         valid_s1;
	logic         adv;

	logic [1:0]   phase_q, phase_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic         suction_q, suction_d;
	logic         toggled;
	logic [2:0]   mask;
	fields_t      field_q, field_d;
	level_t       levels_q [NUM_LEVELS_MAX];
	level_t       levels_d [NUM_LEVELS_MAX];
	level_t       conv_val [NUM_LEVELS_MAX];

	level_t       level_a_q, level_b_q, level_c_q;
	logic         out_valid_q;
	logic         suction_on_q, suction_changed_q;
	logic [2:0]   mask_q;

	// The input stage moves on whenever the result register is free or being emptied.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// One converter for each stored level.
	for (genvar k = 0; k < NUM_LEVELS_MAX; k++) begin : g_conv
		if (k < NUM_LEVELS) begin : g_used
			acfp_conv #(
				.FIELD_CHARS(FIELD_CHARS)
			) u_conv (
				.chars(field_q[k]),
				.value(conv_val[k])
			);
		end else begin : g_unused
			assign conv_val[k] = '0;
		end
	end

	// Next parse state for the byte in the input stage.
	always_comb begin
		phase_d   = phase_q;
		slot_d    = slot_q;
		pos_d     = pos_q;
		suction_d = suction_q;
		field_d   = field_q;
		toggled   = 1'b0;
		mask      = '0;
		for (int k = 0; k < NUM_LEVELS_MAX; k++) begin
			levels_d[k] = levels_q[k];
		end
		case (phase_q)
			PH_START: begin
				for (int f = 0; f < NUM_LEVELS; f++) begin
					for (int i = 0; i < FIELD_CHARS; i++) begin
						field_d[f][i] = CH_SPACE;
					end
				end
				slot_d = '0;
				pos_d  = '0;
				if (byte_s1 == CH_LT) begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				phase_d = PH_END;
				if (byte_s1 == CH_M) begin
					suction_d = 1'b1;
					toggled   = !suction_q;
				end else if (byte_s1 == CH_A || byte_s1 == CH_D) begin
					suction_d = 1'b0;
					toggled   = suction_q;
				end else if (byte_s1 == CH_P) begin
					phase_d = PH_LEVELS;
				end
			end
			PH_LEVELS: begin
				if (byte_s1 == CH_GT) begin
					for (int k = 0; k < NUM_LEVELS; k++) begin
						if (conv_val[k] != levels_q[k]) begin
							levels_d[k] = conv_val[k];
							mask[k]     = 1'b1;
						end
					end
					phase_d = PH_START;
				end else if (byte_s1 == CH_DOT || pos_q == POS_W'(FIELD_CHARS)) begin
					if (slot_q < SLOT_W'(NUM_FIELDS)) begin
						slot_d = slot_q + 1'b1;
					end
					pos_d = '0;
				end else if (slot_q < SLOT_W'(NUM_FIELDS)) begin
					for (int f = 0; f < NUM_LEVELS; f++) begin
						for (int i = 0; i < FIELD_CHARS; i++) begin
							if (slot_q == SLOT_W'(f) && pos_q == POS_W'(i)) begin
								field_d[f][i] = byte_s1;
							end
						end
					end
					pos_d = pos_q + 1'b1;
				end
			end
			default: begin
				if (byte_s1 == CH_GT) begin
					phase_d = PH_START;
				end
			end
		endcase
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			slot_q    <= '0;
			pos_q     <= '0;
			suction_q <= 1'b0;
			for (int k = 0; k < NUM_LEVELS_MAX; k++) begin
				levels_q[k] <= '0;
			end
		end else if (adv) begin
			phase_q   <= phase_d;
			slot_q    <= slot_d;
			pos_q     <= pos_d;
			suction_q <= suction_d;
			for (int k = 0; k < NUM_LEVELS_MAX; k++) begin
				levels_q[k] <= levels_d[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			field_q <= field_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			suction_on_q      <= suction_d;
			suction_changed_q <= toggled;
			level_a_q         <= levels_d[0];
			level_b_q         <= levels_d[1];
			level_c_q         <= levels_d[2];
			mask_q            <= mask;
		end
	end

	assign out_valid          = out_valid_q;
	assign suction_on         = suction_on_q;
	assign suction_changed    = suction_changed_q;
	assign level_a            = level_a_q;
	assign level_b            = level_b_q;
	assign level_c            = level_c_q;
	assign level_changed_mask = mask_q;

	// Checks on the parse state and the pipeline.
	`ACFP_CHECK(a_pos_range, pos_q <= POS_W'(FIELD_CHARS), "char position past field end")
	`ACFP_CHECK(a_slot_range, slot_q <= SLOT_W'(NUM_FIELDS), "field slot past last field")
	`ACFP_CHECK(a_stall_full, !in_ready |-> (valid_s1 && out_valid_q), "input stalled with room")
	`ACFP_CHECK(a_mask_phase,
		(adv && mask != 3'b000) |-> (phase_q == PH_LEVELS && byte_s1 == CH_GT),
		"level update outside frame end")
	`ACFP_CHECK_NEXT(a_toggle, adv,
		suction_changed_q == (suction_q != $past(suction_q)),
		"suction change flag mismatch")

endmodule

`default_nettype wire
